FILE: rtl/core/frpn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame rate negotiator package
// Widths, command and register codes, and reset values that the negotiator
// and its serial divider share.
// ----------------------------------------------------------------------------
package frpn_pkg;

   localparam int RATE_W     = 5;
   localparam int CLIENT_W   = 14;
   localparam int MARGIN_W   = 8;
   localparam int ACC_W      = 32;
   localparam int FC_W       = 16;
   localparam int FRAC_W     = 16;
   localparam int CMD_W      = 3;
   localparam int SIG_W      = 8;
   localparam int FREP_W     = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 14;

   // Divider: the dividend is the client rate scaled by 2^16.
   localparam int DIVIDEND_W = CLIENT_W + FRAC_W;
   localparam int DIVISOR_W  = CLIENT_W;
   localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_FRAME   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_EMIT    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_RECEIVE = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SET_CAP = 3'd3;
   localparam logic [CMD_W-1:0] CMD_RESTART = 3'd4;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_CALL_RATE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLIENT_RATE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MARGIN      = 2'd2;

   // Reset values.
   localparam logic [RATE_W-1:0]   CALL_RATE_RESET   = 5'd30;
   localparam logic [CLIENT_W-1:0] CLIENT_RATE_RESET = 14'd7680;
   localparam logic [MARGIN_W-1:0] MARGIN_RESET      = 8'd26;

   localparam logic [FREP_W-1:0] FORCE_REPEAT_COUNT = 2'd2;
   localparam int                FORCE_BIT          = 5;
   localparam logic [SIG_W-1:0]  SIGNAL_PREFIX      = 8'hC0;
   localparam logic [ACC_W:0]    ROUND_HALF         = 33'h0_0000_8000;
   localparam logic [CLIENT_W:0] CLIENT_ROUND_HALF  = 15'd128;

endpackage

FILE: rtl/core/frame_rate_negotiator_and_pacer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame rate negotiator and pacer
// Tracks own, peer and cap frame rates, paces captured frames down to the
// own rate and builds and parses the rate signal byte.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake             Payload
//   req      in         req_valid/req_ready   cmd, signal_in, cap_value
//   rsp      out        rsp_valid/rsp_ready   keep_frame, signal_out,
//                                             own_rate_out, peer_rate_out
//   csr      in         csr_valid/csr_ready   csr_index, csr_data
//
// A frame command that paces waits on the serial divider, which forms the
// drop ratio one quotient bit per cycle; a nonzero received signal passes
// through S_CLAMP. One command is in flight at a time; req_ready is low from
// acceptance until its result is in the output register. The result register
// lets the next transaction in while a result waits on rsp_ready. Reset is
// synchronous and loads the reset rates; csr writes are always taken.
// ----------------------------------------------------------------------------
module frame_rate_negotiator_and_pacer (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [frpn_pkg::CMD_W-1:0]         req_cmd,
   input  logic [frpn_pkg::SIG_W-1:0]         req_signal_in,
   input  logic [frpn_pkg::RATE_W-1:0]        req_cap_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_keep_frame,
   output logic [frpn_pkg::SIG_W-1:0]         rsp_signal_out,
   output logic [frpn_pkg::RATE_W-1:0]        rsp_own_rate_out,
   output logic [frpn_pkg::RATE_W-1:0]        rsp_peer_rate_out,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [frpn_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [frpn_pkg::CSR_DATA_W-1:0]    csr_data
);
   import frpn_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_DIV,
      S_DROP,
      S_CLAMP,
      S_RESULT
   } state_type;

   state_type             state_ff, state_in;

   logic [RATE_W-1:0]     call_ff, call_in;
   logic [CLIENT_W-1:0]   client_ff, client_in;
   logic [MARGIN_W-1:0]   margin_ff, margin_in;

   logic [RATE_W-1:0]     own_ff, own_in;
   logic [RATE_W-1:0]     peer_ff, peer_in;
   logic [RATE_W-1:0]     own_cap_ff, own_cap_in;
   logic [RATE_W-1:0]     peer_cap_ff, peer_cap_in;
   logic [FREP_W-1:0]     frep_ff, frep_in;
   logic [ACC_W-1:0]      accum_ff, accum_in;
   logic [FC_W-1:0]       fc_ff, fc_in;
   logic                  paced_ff, paced_in;
   logic [ACC_W-1:0]      ratio_ff, ratio_in;

   logic [CMD_W-1:0]      cmd_ff, cmd_in;
   logic [SIG_W-1:0]      sig_req_ff, sig_req_in;
   logic [RATE_W-1:0]     cap_req_ff, cap_req_in;

   logic                  keep_res_ff, keep_res_in;
   logic [SIG_W-1:0]      sig_res_ff, sig_res_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_keep_ff, rsp_keep_in;
   logic [SIG_W-1:0]      rsp_sig_ff, rsp_sig_in;
   logic [RATE_W-1:0]     rsp_own_ff, rsp_own_in;
   logic [RATE_W-1:0]     rsp_peer_ff, rsp_peer_in;

   logic                  div_start;
   logic                  div_done;
   logic [DIVIDEND_W-1:0] div_quo;

   logic [CLIENT_W-1:0]   own_q8;
   logic [CLIENT_W-1:0]   own_margin;
   logic [CLIENT_W-1:0]   diff;
   logic [CLIENT_W:0]     client_round;
   logic [CLIENT_W-CLIENT_W+6:0] round_rate;
   logic [ACC_W:0]        idx_sum;
   logic [FC_W-1:0]       fc_next;
   logic [RATE_W-1:0]     sig_rate;
   logic [RATE_W-1:0]     cap_next;
   logic [5:0]            whole;
   logic [RATE_W-1:0]     clamp_min;
   logic [5:0]            emit_byte;

   assign own_q8       = {1'b0, own_ff, 8'd0};
   assign own_margin   = own_q8 + {6'd0, margin_ff};
   assign diff         = client_ff - own_q8;
   assign client_round = {1'b0, client_ff} + CLIENT_ROUND_HALF;
   assign round_rate   = client_round[CLIENT_W:8];
   assign idx_sum      = {1'b0, accum_ff} + ROUND_HALF;
   assign fc_next      = fc_ff + 1'b1;
   assign sig_rate     = sig_req_ff[RATE_W-1:0];
   assign cap_next     = (call_ff >= sig_rate) ? sig_rate : peer_cap_ff;
   assign whole        = client_ff[CLIENT_W-1:8];
   assign clamp_min    = ({1'b0, call_ff} < whole) ? call_ff : whole[RATE_W-1:0];

   assign div_start = (state_ff == S_EXEC) && (cmd_ff == CMD_FRAME)
                      && (own_margin <= client_ff) && (diff != '0);

   frpn_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({client_ff, {FRAC_W{1'b0}}}),
      .divisor  (diff),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      state_in    = state_ff;
      call_in     = call_ff;
      client_in   = client_ff;
      margin_in   = margin_ff;
      own_in      = own_ff;
      peer_in     = peer_ff;
      own_cap_in  = own_cap_ff;
      peer_cap_in = peer_cap_ff;
      frep_in     = frep_ff;
      accum_in    = accum_ff;
      fc_in       = fc_ff;
      paced_in    = paced_ff;
      ratio_in    = ratio_ff;
      cmd_in      = cmd_ff;
      sig_req_in  = sig_req_ff;
      cap_req_in  = cap_req_ff;
      keep_res_in = keep_res_ff;
      sig_res_in  = sig_res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_keep_in  = rsp_keep_ff;
      rsp_sig_in   = rsp_sig_ff;
      rsp_own_in   = rsp_own_ff;
      rsp_peer_in  = rsp_peer_ff;
      emit_byte    = {1'b0, own_ff};

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in     = req_cmd;
               sig_req_in = req_signal_in;
               cap_req_in = req_cap_value;
               state_in   = S_EXEC;
            end
         end
         S_EXEC: begin
            keep_res_in = 1'b0;
            sig_res_in  = '0;
            state_in    = S_RESULT;
            case (cmd_ff)
               CMD_FRAME: begin
                  if (div_start) begin
                     state_in = S_DIV;
                  end else begin
                     keep_res_in = 1'b1;
                  end
               end
               CMD_EMIT: begin
                  if (frep_ff != '0) begin
                     frep_in   = frep_ff - 1'b1;
                     emit_byte = {1'b0, own_cap_ff};
                     emit_byte[FORCE_BIT] = 1'b1;
                  end else if (client_ff < {1'b0, call_ff, 8'd0}) begin
                     if ({2'b00, own_ff} > round_rate) begin
                        emit_byte = round_rate[5:0];
                     end
                  end
                  sig_res_in = SIGNAL_PREFIX | {2'b00, emit_byte};
               end
               CMD_RECEIVE: begin
                  if (sig_req_ff != '0) begin
                     if (sig_req_ff[FORCE_BIT]) begin
                        peer_cap_in = cap_next;
                        if ((own_ff > cap_next) && (cap_next != '0)) begin
                           own_in = cap_next;
                        end
                     end else begin
                        peer_in = sig_rate;
                     end
                     state_in = S_CLAMP;
                  end
               end
               CMD_SET_CAP: begin
                  frep_in    = FORCE_REPEAT_COUNT;
                  own_cap_in = cap_req_ff;
               end
               CMD_RESTART: begin
                  client_in   = CLIENT_RATE_RESET;
                  own_in      = call_ff;
                  peer_in     = call_ff;
                  own_cap_in  = call_ff;
                  peer_cap_in = call_ff;
                  frep_in     = '0;
                  accum_in    = '0;
                  fc_in       = '0;
                  paced_in    = 1'b0;
               end
               default: begin
               end
            endcase
         end
         S_DIV: begin
            if (div_done) begin
               ratio_in = ACC_W'(div_quo);
               // The first paced frame after restart seeds the accumulator.
               if (!paced_ff) begin
                  accum_in = accum_ff + ACC_W'(div_quo);
                  paced_in = 1'b1;
               end
               state_in = S_DROP;
            end
         end
         S_DROP: begin
            // Drop when the frame count reaches the rounded accumulator.
            if ({1'b0, fc_next} == idx_sum[ACC_W:FRAC_W]) begin
               accum_in    = accum_ff + ratio_ff - {fc_next, {FRAC_W{1'b0}}};
               fc_in       = '0;
               keep_res_in = 1'b0;
            end else begin
               fc_in       = fc_next;
               keep_res_in = 1'b1;
            end
            state_in = S_RESULT;
         end
         S_CLAMP: begin
            if (own_q8 > client_ff) begin
               if (whole != '0) begin
                  own_in = whole[RATE_W-1:0];
               end
            end else if ((own_q8 < client_ff) && (own_ff < call_ff)) begin
               if (clamp_min != '0) begin
                  own_in = clamp_min;
               end
            end
            state_in = S_RESULT;
         end
         S_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_keep_in  = keep_res_ff;
               rsp_sig_in   = sig_res_ff;
               rsp_own_in   = own_ff;
               rsp_peer_in  = peer_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_valid) begin
         case (csr_index)
            CSR_CALL_RATE:   call_in   = csr_data[RATE_W-1:0];
            CSR_CLIENT_RATE: client_in = csr_data[CLIENT_W-1:0];
            CSR_MARGIN:      margin_in = csr_data[MARGIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      ratio_ff    <= ratio_in;
      cmd_ff      <= cmd_in;
      sig_req_ff  <= sig_req_in;
      cap_req_ff  <= cap_req_in;
      keep_res_ff <= keep_res_in;
      sig_res_ff  <= sig_res_in;
      rsp_keep_ff <= rsp_keep_in;
      rsp_sig_ff  <= rsp_sig_in;
      rsp_own_ff  <= rsp_own_in;
      rsp_peer_ff <= rsp_peer_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         call_ff      <= CALL_RATE_RESET;
         client_ff    <= CLIENT_RATE_RESET;
         margin_ff    <= MARGIN_RESET;
         own_ff       <= CALL_RATE_RESET;
         peer_ff      <= CALL_RATE_RESET;
         own_cap_ff   <= CALL_RATE_RESET;
         peer_cap_ff  <= CALL_RATE_RESET;
         frep_ff      <= '0;
         accum_ff     <= '0;
         fc_ff        <= '0;
         paced_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         call_ff      <= call_in;
         client_ff    <= client_in;
         margin_ff    <= margin_in;
         own_ff       <= own_in;
         peer_ff      <= peer_in;
         own_cap_ff   <= own_cap_in;
         peer_cap_ff  <= peer_cap_in;
         frep_ff      <= frep_in;
         accum_ff     <= accum_in;
         fc_ff        <= fc_in;
         paced_ff     <= paced_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready         = (state_ff == S_IDLE);
   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_keep_frame    = rsp_keep_ff;
   assign rsp_signal_out    = rsp_sig_ff;
   assign rsp_own_rate_out  = rsp_own_ff;
   assign rsp_peer_rate_out = rsp_peer_ff;

endmodule

FILE: rtl/core/frpn_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame rate negotiator serial divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module frpn_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [frpn_pkg::DIVIDEND_W-1:0]   dividend,
   input  logic [frpn_pkg::DIVISOR_W-1:0]    divisor,
   output logic                              done,
   output logic [frpn_pkg::DIVIDEND_W-1:0]   quotient
);
   import frpn_pkg::*;

   logic [DIVISOR_W:0]    rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  div_ff, div_in;
   logic [DIV_CNT_W-1:0]  count_ff, count_in;
   logic                  run_ff, run_in;
   logic                  done_ff, done_in;

   logic [DIVISOR_W:0]    trial;
   logic                  fits;

   // The remainder stays below the divisor, so one shifted-in bit fits.
   assign trial = {rem_ff[DIVISOR_W-1:0], quo_ff[DIVIDEND_W-1]};
   assign fits  = (trial >= {1'b0, div_ff});

   always_comb begin
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      div_in   = div_ff;
      count_in = count_ff;
      run_in   = run_ff;
      done_in  = 1'b0;
      if (start) begin
         rem_in   = '0;
         quo_in   = dividend;
         div_in   = divisor;
         count_in = DIV_CNT_W'(DIVIDEND_W);
         run_in   = 1'b1;
      end else if (run_ff) begin
         rem_in   = fits ? (trial - {1'b0, div_ff}) : trial;
         quo_in   = {quo_ff[DIVIDEND_W-2:0], fits};
         count_in = count_ff - 1'b1;
         if (count_ff == DIV_CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      div_ff   <= div_in;
      if (reset) begin
         count_ff <= '0;
         run_ff   <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         run_ff   <= run_in;
         done_ff  <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
